// File: rtl/sobel_edge_magnitude_rgb_assert.svh
// Assertion helpers used by the checker file.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// same-cycle implication
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SEM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/sem_pkg.sv
package sem_pkg;

  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned RGB_W      = NUM_CH * PIX_W;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ROW_CNT_W  = 11;
  localparam int unsigned GRAD_W     = 11;
  localparam int unsigned SQ_W       = 2 * GRAD_W;
  localparam int unsigned RAD_W      = 2 * PIX_W;
  localparam int unsigned SQRT_STEPS = PIX_W;

  localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = 11'd2047;
  localparam logic [SQ_W-1:0]      SQ_LIMIT    = 22'd65280;
  localparam logic [PIX_W-1:0]     MAG_MAX     = 8'd255;
  localparam logic [CFG_W-1:0]     DIM_RESET   = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_START,
    ST_ROOT
  } sem_state_e;

  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] sum;
  } sem_root_req_t;

endpackage

// File: rtl/sem_ram.sv
module sem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sem_sqrt.sv
module sem_sqrt import sem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sem_root_req_t    req_i,
  output logic             done_o,
  output logic [PIX_W-1:0] mag_o
);

  localparam int unsigned CNT_W = $clog2(SQRT_STEPS);
  localparam int unsigned REM_W = PIX_W + 1;
  localparam int unsigned SH_W  = REM_W + 2;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sat_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [PIX_W-1:0] root_q, root_d;
  logic [SH_W-1:0]  rem_sh, trial, diff;
  logic             fits;
  logic [PIX_W:0]   rounded;

  // one root bit per cycle, radicand fed two bits at a time from the top
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);
    rem_d  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_d = {root_q[PIX_W-2:0], fits};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sat_q  <= (req_i.sum > SQ_LIMIT);
      rad_q  <= req_i.sum[RAD_W-1:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  // round up when the remainder exceeds the root
  assign rounded = (rem_q > {1'b0, root_q}) ? ({1'b0, root_q} + (PIX_W+1)'(1))
                                            : {1'b0, root_q};
  assign mag_o   = (sat_q || rounded[PIX_W]) ? MAG_MAX : rounded[PIX_W-1:0];
  assign done_o  = done_q;

endmodule

// File: rtl/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude per RGB channel over a 3x3 window, frame border read as zero.
// One item at a time: s_axis_tready is high only while idle, so a new item waits until
// the last one has been read or, when it yields a result, has left the bit-serial square
// root and been loaded into the output register once that is free; line stores in one RAM.
// Reset (async, active low): frame size 1024 x 1024, positions cleared, output empty;
// line store contents undefined.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [RGB_W-1:0]     s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic                 s_axis_tuser,   // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [RGB_W-1:0]     m_axis_tdata,   // edge_red, edge_green, edge_blue
  output logic                 m_axis_tlast,   // frame_end
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned OROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned RAM_W  = 2 * RGB_W;

  sem_state_e state_q, state_d;

  logic [CFG_W-1:0]     fwidth_q, fheight_q;
  logic                 cfg_wr_w, cfg_wr_h;
  logic [WDIM_W-1:0]    w_dim;
  logic [HDIM_W-1:0]    h_dim;

  logic [COL_W-1:0]     in_col_q, acol_q, out_col_q;
  logic [ROW_CNT_W-1:0] in_row_q;
  logic [OROW_W-1:0]    out_row_q;
  logic                 in_col_last, out_col_last, out_row_last, frame_last;
  logic                 emit_now, emit_q;
  logic [RGB_W-1:0]     pix_q;

  logic                 in_acc, load_out;
  logic                 ram_we;
  logic [RAM_W-1:0]     ram_wdata, ram_rdata;

  logic [RGB_W-1:0]     win_q [9];
  logic [RGB_W-1:0]     win_d [9];
  logic                 row_on [3];
  logic                 col_on [3];
  grad_t                tap [NUM_CH][9];
  grad_t                gx_d [NUM_CH];
  grad_t                gy_d [NUM_CH];
  grad_t                gx_q [NUM_CH];
  grad_t                gy_q [NUM_CH];
  logic [SQ_W-1:0]      sqx_q [NUM_CH];
  logic [SQ_W-1:0]      sqy_q [NUM_CH];

  sem_root_req_t        root_req [NUM_CH];
  logic [NUM_CH-1:0]    root_done;
  logic [PIX_W-1:0]     root_mag [NUM_CH];

  logic                 m_valid_q, m_valid_d;
  logic [RGB_W-1:0]     m_data_q;
  logic                 m_last_q;

  // configuration
  always_comb begin
    cfg_wr_w = 1'b0;
    cfg_wr_h = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_wr_w = 1'b1;
        REG_FRAME_HEIGHT: cfg_wr_h = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q  <= DIM_RESET;
      fheight_q <= DIM_RESET;
    end else begin
      if (cfg_wr_w) fwidth_q <= cfg_wdata_i;
      if (cfg_wr_h) fheight_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (fwidth_q == '0) begin
      w_dim = WDIM_W'(1);
    end else if (32'(fwidth_q) > MAX_WIDTH) begin
      w_dim = WDIM_W'(MAX_WIDTH);
    end else begin
      w_dim = WDIM_W'(fwidth_q);
    end
    if (fheight_q == '0) begin
      h_dim = HDIM_W'(1);
    end else if (32'(fheight_q) > MAX_HEIGHT) begin
      h_dim = HDIM_W'(MAX_HEIGHT);
    end else begin
      h_dim = HDIM_W'(fheight_q);
    end
  end

  // positions
  assign in_col_last  = (32'(in_col_q) + 32'd1) >= 32'(w_dim);
  assign out_col_last = (32'(out_col_q) + 32'd1) >= 32'(w_dim);
  assign out_row_last = (32'(out_row_q) + 32'd1) >= 32'(h_dim);
  assign frame_last   = out_row_last && out_col_last;
  assign emit_now     = (in_row_q >= ROW_CNT_W'(2)) ||
                        ((in_row_q == ROW_CNT_W'(1)) && (in_col_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_wr_w || cfg_wr_h) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (in_acc) begin
        if (in_col_last) begin
          in_col_q <= '0;
          if (in_row_q != ROW_CNT_MAX) in_row_q <= in_row_q + ROW_CNT_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end
      if (load_out) begin
        if (frame_last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (out_col_last) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + OROW_W'(1);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ST_READ;
      end
      ST_READ:   state_d = emit_q ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_d = ST_START;
      ST_START:  state_d = ST_ROOT;
      ST_ROOT: begin
        if ((&root_done) && (!m_valid_q || m_axis_tready)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acol_q <= in_col_q;
      emit_q <= emit_now;
      pix_q  <= (!s_axis_tuser && (32'(in_row_q) < 32'(h_dim))) ? s_axis_tdata : '0;
    end
  end

  // line stores: upper row in the low half, middle row in the high half
  assign ram_we    = (state_q == ST_READ);
  assign ram_wdata = {pix_q, ram_rdata[RAM_W-1:RGB_W]};

  sem_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (acol_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // window shift and gradients
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = ram_rdata[RGB_W-1:0];
    win_d[5] = ram_rdata[RAM_W-1:RGB_W];
    win_d[8] = pix_q;
  end

  always_comb begin
    row_on[0] = (out_row_q != '0);
    row_on[1] = 1'b1;
    row_on[2] = !out_row_last;
    col_on[0] = (out_col_q != '0);
    col_on[1] = 1'b1;
    col_on[2] = !out_col_last;
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          tap[ch][r*3+c] = (row_on[r] && col_on[c]) ?
            grad_t'({{(GRAD_W-PIX_W){1'b0}}, win_d[r*3+c][ch*PIX_W +: PIX_W]}) : '0;
        end
      end
      gx_d[ch] = (tap[ch][2] - tap[ch][0]) + ((tap[ch][5] - tap[ch][3]) <<< 1)
               + (tap[ch][8] - tap[ch][6]);
      gy_d[ch] = (tap[ch][6] - tap[ch][0]) + ((tap[ch][7] - tap[ch][1]) <<< 1)
               + (tap[ch][8] - tap[ch][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      for (int k = 0; k < 9; k++) win_q[k] <= win_d[k];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
    end
    if (state_q == ST_SQUARE) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sqx_q[ch] <= $unsigned(SQ_W'(gx_q[ch]) * SQ_W'(gx_q[ch]));
        sqy_q[ch] <= $unsigned(SQ_W'(gy_q[ch]) * SQ_W'(gy_q[ch]));
      end
    end
  end

  // square roots, one per channel
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_root
    assign root_req[ch].start = (state_q == ST_START);
    assign root_req[ch].sum   = sqx_q[ch] + sqy_q[ch];

    sem_sqrt u_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (root_req[ch]),
      .done_o (root_done[ch]),
      .mag_o  (root_mag[ch])
    );
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {root_mag[2], root_mag[1], root_mag[0]};
      m_last_q <= frame_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// File: rtl/sem_checker.sv
`include "sobel_edge_magnitude_rgb_assert.svh"

module sem_checker import sem_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [RGB_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  `SEM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SEM_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `SEM_ASSERT_NXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SEM_ASSERT_IMP(a_result_busy, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sem_pkg::*;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int CLAMP_ITEMS   = 24;
  localparam int RANDOM_ITEMS  = 840;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    logic             last;
    logic [RGB_W-1:0] rgb;   // red, green, blue from the lowest bit up
  } edge_res_t;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       val;
    logic                   cmd;
    logic [RGB_W-1:0]       pix;
    bit                     typed;
    edge_res_t              res;
  } script_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [RGB_W-1:0]     s_axis_tdata  = '0;   // pixel_red, pixel_green, pixel_blue
  logic                 s_axis_tuser  = 1'b0; // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RGB_W-1:0]     m_axis_tdata;         // edge_red, edge_green, edge_blue
  logic                 m_axis_tlast;         // frame_end
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;

  // predictor state
  logic [CFG_W-1:0] width_reg  = DIM_RESET;
  logic [CFG_W-1:0] height_reg = DIM_RESET;
  logic [RGB_W-1:0] upper_row  [MAX_W];
  logic [RGB_W-1:0] middle_row [MAX_W];
  logic [RGB_W-1:0] win        [9];
  int in_col, in_row, out_col, out_row;

  edge_res_t edge_q[$];
  int fault_count   = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int frames_done   = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  sobel_edge_magnitude_rgb #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int dim_clamp(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void restart_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // rounded integer root of gx^2 + gy^2, saturated
  function automatic logic [7:0] edge_mag(input int gx, input int gy);
    int unsigned s, q, t;
    s = gx * gx + gy * gy;
    if (s > SQ_LIMIT) return MAG_MAX;
    q = 0;
    for (int b = 7; b >= 0; b--) begin
      t = q | (1 << b);
      if (t * t <= s) q = t;
    end
    if (s > q * q + q) q++;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic bit sobel_predict(input logic cmd, input logic [RGB_W-1:0] pix,
                                       output edge_res_t res);
    int w, h, col, gx, gy, v;
    logic [RGB_W-1:0] px;
    bit emit;
    w   = dim_clamp(width_reg, MAX_W);
    h   = dim_clamp(height_reg, MAX_H);
    res = '0;
    col = in_col % MAX_W;
    px  = (cmd == CMD_PIXEL && in_row < h) ? pix : '0;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = upper_row[col];
    win[5] = middle_row[col];
    win[8] = px;
    upper_row[col]  = middle_row[col];
    middle_row[col] = px;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < int'(ROW_CNT_MAX)) in_row++;
    end
    if (!emit) return 0;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
              (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w)) continue;
          v = win[r*3+c][8*ch +: 8];
          gx += (c - 1) * (r == 1 ? 2 : 1) * v;
          gy += (r - 1) * (c == 1 ? 2 : 1) * v;
        end
      end
      res.rgb[8*ch +: 8] = edge_mag(gx, gy);
    end
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (res.last) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1;
  endfunction

  function automatic logic [RGB_W-1:0] rand_pixel();
    logic [RGB_W-1:0] p;
    int sel;
    sel = $urandom_range(9);
    p   = RGB_W'($urandom);
    for (int ch = 0; ch < 3; ch++) begin
      if (sel >= 7) p[8*ch +: 8] = 8'($urandom_range(100, 140));
      else if (sel >= 4) p[8*ch +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
    script_row_t row;
    row       = '{ROW_CFG, idx, val, CMD_PIXEL, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic script_row_t item_row(input logic cmd, input logic [RGB_W-1:0] pix);
    script_row_t row;
    row       = '{ROW_ITEM, REG_FRAME_WIDTH, '0, cmd, pix, 1'b0, '0};
    return row;
  endfunction

  task automatic set_idling(input idling_e mode);
    send_idle_pct  = (mode == IDLE_SENDER)   ? 62 : (mode == IDLE_BOTH) ? 28 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 28 : 0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = val;
        restart_positions();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = val;
        restart_positions();
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic cmd, input logic [RGB_W-1:0] pix,
                           input bit typed, input edge_res_t typed_res);
    edge_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (sobel_predict(cmd, pix, res)) edge_q.push_back(typed ? typed_res : res);
  endtask

  task automatic check_result(input logic [RGB_W-1:0] rgb, input logic last);
    edge_res_t want;
    bit bad;
    results_seen++;
    if (edge_q.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected result: r=%0d g=%0d b=%0d last=%b",
                 rgb[7:0], rgb[15:8], rgb[23:16], last);
      return;
    end
    want = edge_q.pop_front();
    bad  = 1'b0;
    for (int ch = 0; ch < 3; ch++)
      if (rgb[8*ch +: 8] !== want.rgb[8*ch +: 8]) bad = 1'b1;
    if (last !== want.last) bad = 1'b1;
    if (bad) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch: exp r=%0d g=%0d b=%0d last=%b, got r=%0d g=%0d b=%0d last=%b",
                 want.rgb[7:0], want.rgb[15:8], want.rgb[23:16], want.last,
                 rgb[7:0], rgb[15:8], rgb[23:16], last);
    end
  endtask

  // result side: check, then choose tready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
      if (hold_asks != hold_seen) begin
        hold_seen     <= hold_asks;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    script_row_t script[$];
    script_row_t row;
    int w, h, total, stop_at, sel, wv, hv, start_count;
    bit need_cfg, pressure;
    logic cmd;

    for (int i = 0; i < MAX_W; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    restart_positions();

    // 1x1 frame via zero sizes; the trailing pixel is late and counts as drain
    script.push_back(cfg_row(REG_FRAME_WIDTH, 11'd0));
    script.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd0));
    script.push_back(item_row(CMD_PIXEL, 24'hFFFFFF));
    script.push_back(item_row(CMD_DRAIN, 24'h000000));
    row = item_row(CMD_PIXEL, 24'h123456);
    row.typed = 1'b1;
    row.res   = '{last: 1'b1, rgb: '0};
    script.push_back(row);
    // 3x2 frame with an early drain and a late pixel
    script.push_back(cfg_row(REG_FRAME_WIDTH, 11'd3));
    script.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd2));
    script.push_back(item_row(CMD_PIXEL, 24'hFFFFFF));
    script.push_back(item_row(CMD_PIXEL, 24'h000000));
    script.push_back(item_row(CMD_PIXEL, 24'hFFFFFF));
    script.push_back(item_row(CMD_DRAIN, 24'hFFFFFF));
    script.push_back(item_row(CMD_PIXEL, 24'hFFFFFF));
    script.push_back(item_row(CMD_PIXEL, 24'h000000));
    script.push_back(item_row(CMD_DRAIN, 24'h000000));
    script.push_back(item_row(CMD_PIXEL, 24'hABCDEF));
    script.push_back(item_row(CMD_DRAIN, 24'h5A5A5A));
    script.push_back(item_row(CMD_DRAIN, 24'h000000));
    // unused indices leave everything alone
    script.push_back(cfg_row(REG_SPARE_A, 11'd5));
    script.push_back(cfg_row(REG_SPARE_B, 11'h7FF));
    // part frame, then size change restarts at the top left
    script.push_back(item_row(CMD_PIXEL, 24'h00FF00));
    script.push_back(item_row(CMD_PIXEL, 24'h0000FF));
    script.push_back(item_row(CMD_PIXEL, 24'hFF0000));
    script.push_back(item_row(CMD_PIXEL, 24'h808080));
    script.push_back(cfg_row(REG_FRAME_HEIGHT, 11'd1));
    script.push_back(cfg_row(REG_FRAME_WIDTH, 11'd2));
    script.push_back(item_row(CMD_PIXEL, 24'h1E140A));
    script.push_back(item_row(CMD_PIXEL, 24'h3264C8));
    script.push_back(item_row(CMD_DRAIN, 24'h000000));
    row = item_row(CMD_DRAIN, 24'h000000);
    row.typed = 1'b1;
    row.res   = '{last: 1'b0, rgb: {8'd100, 8'd200, 8'd255}};
    script.push_back(row);
    row = item_row(CMD_DRAIN, 24'h000000);
    row.typed = 1'b1;
    row.res   = '{last: 1'b1, rgb: {8'd60, 8'd40, 8'd20}};
    script.push_back(row);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(IDLE_NONE);
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) write_reg(script[i].idx, script[i].val);
      else push_item(script[i].cmd, script[i].pix, script[i].typed, script[i].res);
    end

    // oversize values clamp to the maximum; a short run into the first row
    set_idling(IDLE_RECEIVER);
    write_reg(REG_FRAME_WIDTH, 11'h7FF);
    write_reg(REG_FRAME_HEIGHT, 11'h7FF);
    for (int k = 0; k < CLAMP_ITEMS; k++) push_item(CMD_PIXEL, rand_pixel(), 1'b0, '0);
    need_cfg = 1'b1;

    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      set_idling(idling_e'((frames_done / 3) % 4));
      pressure = (frames_done == 5 || frames_done == 30);
      if (pressure) begin
        send_idle_pct = 0;
        write_reg(REG_FRAME_WIDTH, 11'd16);
        write_reg(REG_FRAME_HEIGHT, 11'd4);
      end else if (need_cfg || $urandom_range(2) == 0) begin
        if ($urandom_range(7) == 0)
          write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        sel = $urandom_range(99);
        wv  = sel < 4 ? 0 : sel < 70 ? $urandom_range(1, 6) :
              sel < 95 ? $urandom_range(7, 32) : $urandom_range(33, 100);
        sel = $urandom_range(99);
        hv  = sel < 4 ? 0 : sel < 80 ? $urandom_range(1, 5) : $urandom_range(6, 12);
        if (wv > 32) hv = $urandom_range(1, 2);
        write_reg(REG_FRAME_WIDTH, CFG_W'(wv));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(hv));
      end
      w       = dim_clamp(width_reg, MAX_W);
      h       = dim_clamp(height_reg, MAX_H);
      total   = w * h + w + 1;
      stop_at = total;
      need_cfg = 1'b0;
      if (!pressure && total > 1 && $urandom_range(99) < 10) begin
        stop_at  = $urandom_range(1, total - 1);
        need_cfg = 1'b1;
      end
      if (pressure) hold_asks <= hold_asks + 1;
      for (int k = 0; k < stop_at; k++) begin
        if (k < w * h) cmd = ($urandom_range(99) < 4) ? CMD_DRAIN : CMD_PIXEL;
        else cmd = ($urandom_range(99) < 25) ? CMD_PIXEL : CMD_DRAIN;
        push_item(cmd, rand_pixel(), 1'b0, '0);
      end
      frames_done++;
    end

    wait_idle();
    if (edge_q.size() != 0) begin
      fault_count += edge_q.size();
      $display("%0d expected results never arrived", edge_q.size());
    end
    $display("%0d items in, %0d results checked, %0d random frames after a clamped-size run",
             items_sent, results_seen, frames_done);
    $display("covered early drains, late pixels, size writes mid-frame, clamped sizes");
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
